// ===== design/i2cm_pkg.sv =====
// Shared types and codes for the I2C master bit engine.
package i2cm_pkg;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WRITE    = 3'd3;
    localparam logic [2:0] OP_READ_ACK = 3'd4;
    localparam logic [2:0] OP_READ_NAK = 3'd5;
    localparam logic [2:0] OP_WAIT_ACK = 3'd6;

    localparam logic [1:0] LIMIT_ADDR    = 2'd0;

    localparam logic [7:0] TOP_BIT       = 8'h80;
    localparam logic [7:0] LIMIT_DEFAULT = 8'd250;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       sda_sample;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_t;

endpackage

// ===== design/i2c_master_bit_engine_top.sv =====
// Top level of the I2C master bit engine: request ports, APB register, result register.
//
//   channel  | ports                       | payload
//   request  | s_valid s_ready s_data      | i2cm_pkg::in_t
//   result   | m_valid m_ready m_data      | i2cm_pkg::out_t
//   config   | psel penable pwrite paddr.. | ack_timeout_limit at 0x0
//
// One request per cycle while s_ready is high; each gives one result, registered and valid in the next cycle.
// The sequencer state and the result register load in the same cycle.
// s_ready is low only while a result is held and m_ready is low.
// Reset: bus idle high, SDA driven, limit 250, no result pending.
module i2c_master_bit_engine_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  i2cm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output i2cm_pkg::out_t m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import i2cm_pkg::*;

    logic [7:0] limit_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;
    out_t       res;
    logic       accept;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {24'd0, limit_reg};

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    i2cm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (accept),
        .req        (s_data),
        .limit      (limit_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_DEFAULT;
        end else if (cfg_write && (paddr == LIMIT_ADDR)) begin
            limit_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

endmodule

// ===== design/i2cm_seq.sv =====
// Bus sequencer: phase state, shifters and pin levels, advanced once per request.
module i2cm_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_accept,
    input  i2cm_pkg::in_t req,
    input  logic [7:0]    limit,
    output i2cm_pkg::out_t res
);
    import i2cm_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_ST_A  = 4'd1;
    localparam logic [3:0] PH_ST_B  = 4'd2;
    localparam logic [3:0] PH_SP_A  = 4'd3;
    localparam logic [3:0] PH_SP_B  = 4'd4;
    localparam logic [3:0] PH_WR_HI = 4'd5;
    localparam logic [3:0] PH_WR_LO = 4'd6;
    localparam logic [3:0] PH_RD_LO = 4'd7;
    localparam logic [3:0] PH_RD_HI = 4'd8;
    localparam logic [3:0] PH_AK_LO = 4'd9;
    localparam logic [3:0] PH_AK_HI = 4'd10;
    localparam logic [3:0] PH_WA_A  = 4'd11;
    localparam logic [3:0] PH_WA_B  = 4'd12;

    logic [3:0] phase_reg, phase_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] rx_reg, rx_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [7:0] tmo_reg, tmo_next;
    logic       fail_reg, fail_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       oe_reg, oe_next;
    logic       done;

    always_comb begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        rx_next      = rx_reg;
        cmd_next     = cmd_reg;
        tmo_next     = tmo_reg;
        fail_next    = fail_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        oe_next      = oe_reg;
        done         = 1'b0;
        if (req.operation == OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                case (phase_reg)
                    PH_ST_A: begin
                        sda_next   = 1'b0;
                        phase_next = PH_ST_B;
                    end
                    PH_ST_B: begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SP_A: begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PH_SP_B;
                    end
                    PH_SP_B: begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WR_HI: begin
                        scl_next   = 1'b0;
                        phase_next = PH_WR_LO;
                    end
                    PH_WR_LO: begin
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        if (bit_cnt_next[3]) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            sda_next   = |(shift_reg & TOP_BIT);
                            shift_next = {shift_reg[6:0], 1'b0};
                            scl_next   = 1'b1;
                            phase_next = PH_WR_HI;
                        end
                    end
                    PH_RD_LO: begin
                        scl_next     = 1'b1;
                        shift_next   = {shift_reg[6:0], req.sda_sample};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = PH_RD_HI;
                    end
                    PH_RD_HI: begin
                        scl_next = 1'b0;
                        if (bit_cnt_reg[3]) begin
                            oe_next    = 1'b1;
                            sda_next   = (cmd_reg != OP_READ_ACK);
                            phase_next = PH_AK_LO;
                        end else begin
                            phase_next = PH_RD_LO;
                        end
                    end
                    PH_AK_LO: begin
                        scl_next   = 1'b1;
                        phase_next = PH_AK_HI;
                    end
                    PH_AK_HI: begin
                        scl_next   = 1'b0;
                        rx_next    = shift_reg;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WA_A: begin
                        scl_next   = 1'b1;
                        phase_next = PH_WA_B;
                    end
                    PH_WA_B: begin
                        if (!req.sda_sample) begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else if (tmo_reg >= limit) begin
                            fail_next  = 1'b1;
                            oe_next    = 1'b1;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_SP_A;
                        end else begin
                            tmo_next = tmo_reg + 8'd1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end else if (phase_reg == PH_IDLE) begin
            case (req.operation)
                OP_START: begin
                    cmd_next   = req.operation;
                    oe_next    = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST_A;
                end
                OP_STOP: begin
                    cmd_next   = req.operation;
                    oe_next    = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_A;
                end
                OP_WRITE: begin
                    cmd_next     = req.operation;
                    oe_next      = 1'b1;
                    bit_cnt_next = 4'd0;
                    sda_next     = |(req.tx_byte & TOP_BIT);
                    shift_next   = {req.tx_byte[6:0], 1'b0};
                    scl_next     = 1'b1;
                    phase_next   = PH_WR_HI;
                end
                OP_READ_ACK, OP_READ_NAK: begin
                    cmd_next     = req.operation;
                    oe_next      = 1'b0;
                    scl_next     = 1'b0;
                    shift_next   = 8'd0;
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_RD_LO;
                end
                OP_WAIT_ACK: begin
                    cmd_next   = req.operation;
                    oe_next    = 1'b0;
                    sda_next   = 1'b1;
                    tmo_next   = 8'd0;
                    fail_next  = 1'b0;
                    phase_next = PH_WA_A;
                end
                default: begin
                    cmd_next = cmd_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'd0;
            rx_reg      <= 8'd0;
            cmd_reg     <= 3'd0;
            tmo_reg     <= 8'd0;
            fail_reg    <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            oe_reg      <= 1'b1;
        end else if (req_accept) begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            rx_reg      <= rx_next;
            cmd_reg     <= cmd_next;
            tmo_reg     <= tmo_next;
            fail_reg    <= fail_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            oe_reg      <= oe_next;
        end
    end

    always_comb begin
        res.scl_level        = scl_next;
        res.sda_level        = sda_next;
        res.sda_drive_enable = oe_next;
        res.busy_res         = (phase_next != PH_IDLE);
        res.done_res         = done;
        res.rx_byte          = rx_next;
        res.ack_failed       = fail_next;
    end

endmodule

// ===== design/i2cm_checker.sv =====
// Port-level checker for the I2C master bit engine, bound to the top level.
module i2cm_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input i2cm_pkg::out_t m_data
);
    import i2cm_pkg::*;

    a_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request side stalled without a held result");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request gave no result");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done reported while still busy");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
